[hdl/divenum_pkg.sv]
// shared constants, controller states and controller/datapath interface types
package divenum_pkg;

  localparam int NUM_WIDTH_DEF = 13;
  localparam int MAX_SMALL_DEF = 32;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_TDIV,
    ST_S_RD,
    ST_S_LD,
    ST_S_OUT,
    ST_L_RD,
    ST_L_START,
    ST_L_WAIT,
    ST_L_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic div_start;
    logic div_from_mem;
    logic store;
    logic d_inc;
    logic idx_clear;
    logic idx_mirror;
    logic idx_inc;
    logic idx_dec;
    logic rd_en;
    logic out_small;
    logic out_large;
    logic out_last;
  } dp_cmd_t;

  typedef struct packed {
    logic n_zero;
    logic dd_le;
    logic div_done;
    logic small_last;
    logic mirror_zero;
    logic idx_first;
  } dp_status_t;

endpackage

[hdl/divenum_div.sv]
// restoring radix-2 divider, one quotient bit per cycle
module divenum_div
  import divenum_pkg::*;
#(
  parameter int NUM_WIDTH = NUM_WIDTH_DEF,
  parameter int SD_W      = (NUM_WIDTH_DEF + 1) / 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [NUM_WIDTH-1:0] dividend,
  input  logic [SD_W-1:0]      divisor,
  output logic                 done,
  output logic [NUM_WIDTH-1:0] quotient,
  output logic [SD_W-1:0]      remainder
);

  localparam int STEP_W = $clog2(NUM_WIDTH + 1);

  logic                 busy_r, busy_nxt;
  logic [STEP_W-1:0]    step_r, step_nxt;
  logic [NUM_WIDTH-1:0] q_r;
  logic [SD_W-1:0]      rem_r;
  logic [SD_W-1:0]      dv_r;
  logic [SD_W:0]        trial;
  logic                 fits;

  assign trial = {rem_r, q_r[NUM_WIDTH-1]};
  assign fits  = (trial >= {1'b0, dv_r});
  assign done  = busy_r && (step_r == '0);

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = STEP_W'(NUM_WIDTH);
    end else if (done) begin
      busy_nxt = 1'b0;
    end else if (busy_r) begin
      step_nxt = step_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dv_r  <= divisor;
    end else if (busy_r && (step_r != '0)) begin
      q_r <= {q_r[NUM_WIDTH-2:0], fits};
      if (fits) begin
        rem_r <= SD_W'(trial - {1'b0, dv_r});
      end else begin
        rem_r <= trial[SD_W-1:0];
      end
    end
  end

  assign quotient  = q_r;
  assign remainder = rem_r;

endmodule

[hdl/divenum_dp.sv]
// datapath: trial counter, square test, small divisor store, divider and result register
module divenum_dp
  import divenum_pkg::*;
#(
  parameter int NUM_WIDTH = NUM_WIDTH_DEF,
  parameter int MAX_SMALL = MAX_SMALL_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [NUM_WIDTH-1:0] in_number,
  input  dp_cmd_t              cmd,
  output dp_status_t           status,
  output logic [NUM_WIDTH-1:0] out_divisor,
  output logic                 out_is_last
);

  localparam int SD_W  = (NUM_WIDTH + 1) / 2;
  localparam int D_W   = SD_W + 1;
  localparam int SQ_W  = 2 * D_W;
  localparam int IDX_W = $clog2(MAX_SMALL);
  localparam int CNT_W = $clog2(MAX_SMALL + 1);

  logic [NUM_WIDTH-1:0] n_r;
  logic [D_W-1:0]       d_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 sq_r;
  logic [IDX_W-1:0]     idx_r;
  logic [SD_W-1:0]      mem [MAX_SMALL];
  logic [SD_W-1:0]      rd_data_r;
  logic [NUM_WIDTH-1:0] out_divisor_r;
  logic                 out_is_last_r;

  logic [SQ_W-1:0]      dd;
  logic [SQ_W-1:0]      n_ext;
  logic                 dd_eq;
  logic                 mem_we;
  logic [CNT_W-1:0]     mirror;
  logic [SD_W-1:0]      div_dv;
  logic                 div_done;
  logic [NUM_WIDTH-1:0] div_q;
  logic [SD_W-1:0]      div_rem;

  assign dd     = d_r * d_r;
  assign n_ext  = SQ_W'(n_r);
  assign dd_eq  = (dd == n_ext);
  assign mirror = cnt_r - CNT_W'(sq_r);
  // a trial divisor is only stored while the store has room
  assign mem_we = cmd.store && (div_rem == '0) && (cnt_r < CNT_W'(MAX_SMALL));
  assign div_dv = cmd.div_from_mem ? rd_data_r : d_r[SD_W-1:0];

  divenum_div #(
    .NUM_WIDTH (NUM_WIDTH),
    .SD_W      (SD_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (n_r),
    .divisor   (div_dv),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      sq_r  <= 1'b0;
      d_r   <= '0;
      idx_r <= '0;
    end else begin
      if (cmd.load) begin
        cnt_r <= '0;
        sq_r  <= 1'b0;
        d_r   <= D_W'(1);
      end else begin
        if (mem_we) begin
          cnt_r <= cnt_r + 1'b1;
          sq_r  <= dd_eq;
        end
        if (cmd.d_inc) begin
          d_r <= d_r + 1'b1;
        end
      end
      if (cmd.idx_clear) begin
        idx_r <= '0;
      end else if (cmd.idx_mirror) begin
        idx_r <= IDX_W'(mirror - 1'b1);
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + 1'b1;
      end else if (cmd.idx_dec) begin
        idx_r <= idx_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_r <= in_number;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cnt_r[IDX_W-1:0]] <= d_r[SD_W-1:0];
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_small) begin
      out_divisor_r <= NUM_WIDTH'(rd_data_r);
      out_is_last_r <= cmd.out_last;
    end else if (cmd.out_large) begin
      out_divisor_r <= div_q;
      out_is_last_r <= cmd.out_last;
    end
  end

  assign status.n_zero      = (n_r == '0);
  assign status.dd_le       = (dd <= n_ext);
  assign status.div_done    = div_done;
  assign status.small_last  = (CNT_W'(idx_r) + 1'b1 == cnt_r);
  assign status.mirror_zero = (mirror == '0);
  assign status.idx_first   = (idx_r == '0);

  assign out_divisor = out_divisor_r;
  assign out_is_last = out_is_last_r;

endmodule

[hdl/divenum_ctrl.sv]
// controller: sequences trial division, small divisor readout and mirrored divisions
module divenum_ctrl
  import divenum_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.n_zero) begin
          state_nxt = ST_IDLE;
        end else if (status.dd_le) begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_TDIV;
        end else begin
          cmd.idx_clear = 1'b1;
          state_nxt     = ST_S_RD;
        end
      end
      ST_TDIV: begin
        if (status.div_done) begin
          cmd.store = 1'b1;
          cmd.d_inc = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_S_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = ST_S_LD;
      end
      ST_S_LD: begin
        cmd.out_small = 1'b1;
        cmd.out_last  = status.small_last && status.mirror_zero;
        state_nxt     = ST_S_OUT;
      end
      ST_S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          priority if (!status.small_last) begin
            cmd.idx_inc = 1'b1;
            state_nxt   = ST_S_RD;
          end else if (status.mirror_zero) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.idx_mirror = 1'b1;
            state_nxt      = ST_L_RD;
          end
        end
      end
      ST_L_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = ST_L_START;
      end
      ST_L_START: begin
        cmd.div_start    = 1'b1;
        cmd.div_from_mem = 1'b1;
        state_nxt        = ST_L_WAIT;
      end
      ST_L_WAIT: begin
        if (status.div_done) begin
          cmd.out_large = 1'b1;
          cmd.out_last  = status.idx_first;
          state_nxt     = ST_L_OUT;
        end
      end
      ST_L_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (status.idx_first) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.idx_dec = 1'b1;
            state_nxt   = ST_L_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

[hdl/divisor_enumerator_core.sv]
// Takes one number at a time and returns all of its divisors in ascending order,
// one result request per divisor, with out_is_last set on the final one (the number
// itself). Candidates d = 1, 2, ... with d*d <= number are tried on a shared
// restoring divider that yields one quotient bit per cycle; hits are kept in an
// on-chip store of MAX_SMALL entries. Then the stored divisors are returned and
// their mirrors number / d are computed on the same divider in reverse order, with
// a perfect square's root given once. A new number is taken only after the last
// result of the previous one has been delivered; a zero input yields no results.
module divisor_enumerator_core
  import divenum_pkg::*;
#(
  parameter int NUM_WIDTH = NUM_WIDTH_DEF,
  parameter int MAX_SMALL = MAX_SMALL_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [NUM_WIDTH-1:0] in_number,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [NUM_WIDTH-1:0] out_divisor,
  output logic                 out_is_last
);

  dp_cmd_t    cmd;
  dp_status_t status;

  divenum_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  divenum_dp #(
    .NUM_WIDTH (NUM_WIDTH),
    .MAX_SMALL (MAX_SMALL)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_number   (in_number),
    .cmd         (cmd),
    .status      (status),
    .out_divisor (out_divisor),
    .out_is_last (out_is_last)
  );

endmodule

[hdl/divenum_chk.sv]
// port-level checker for the divisor enumerator, bound to the top level
module divenum_chk
  import divenum_pkg::*;
#(
  parameter int NUM_WIDTH = NUM_WIDTH_DEF
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [NUM_WIDTH-1:0] out_divisor,
  input logic                 out_is_last
);

  // a waiting result holds still
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_divisor) && $stable(out_is_last))
    else $error("result changed while stalled");

  // one number at a time: no new request while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while result pending");

  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready && !out_valid)
    else $error("block not busy after taking a number");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_is_last |=> !out_valid)
    else $error("result after last divisor");

  a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_divisor != '0)
    else $error("zero divisor returned");

endmodule

bind divisor_enumerator_core divenum_chk #(.NUM_WIDTH(NUM_WIDTH)) u_divenum_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_divisor (out_divisor),
  .out_is_last (out_is_last)
);

[tb/sv/tb_divisor_enumerator_core.sv]
// testbench for divisor_enumerator_core: directed numbers then random ones, each divisor checked
module tb_divisor_enumerator_core
  import divenum_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_W        = NUM_WIDTH_DEF;
  localparam int SMALL_CAP    = MAX_SMALL_DEF;
  localparam int NUM_MAX      = (1 << NUM_W) - 1;
  localparam int RST_CYCLES   = 11;
  localparam int RAND_ITEMS   = 247;
  localparam int CALM_ITEMS   = 40;
  localparam int LONG_HOLD    = 4000;
  localparam int DRAIN_CYCLES = 2000;
  localparam int TIMEOUT_NS   = 60_000_000;

  typedef struct packed {
    logic [NUM_W-1:0] divisor;
    logic             is_last;
  } div_result_t;

  typedef struct packed {
    logic [NUM_W-1:0] number;
    logic [1:0]       n_fixed;
    logic [NUM_W-1:0] f0;
    logic [NUM_W-1:0] f1;
    logic [NUM_W-1:0] f2;
  } stim_row_t;

  // rows with n_fixed of zero are left to the predictor
  localparam stim_row_t STIM_TAB [23] = '{
    '{13'd1,    2'd1, 13'd1, 13'd0,    13'd0},
    '{13'd2,    2'd2, 13'd1, 13'd2,    13'd0},
    '{13'd3,    2'd2, 13'd1, 13'd3,    13'd0},
    '{13'd4,    2'd3, 13'd1, 13'd2,    13'd4},
    '{13'd8191, 2'd2, 13'd1, 13'd8191, 13'd0},
    '{13'd8190, 2'd0, 13'd0, 13'd0,    13'd0},
    '{13'd8100, 2'd0, 13'd0, 13'd0,    13'd0},
    '{13'd8099, 2'd0, 13'd0, 13'd0,    13'd0},
    '{13'd4096, 2'd0, 13'd0, 13'd0,    13'd0},
    '{13'd4095, 2'd0, 13'd0, 13'd0,    13'd0},
    '{13'd7560, 2'd0, 13'd0, 13'd0,    13'd0},
    '{13'd5040, 2'd0, 13'd0, 13'd0,    13'd0},
    '{13'd6720, 2'd0, 13'd0, 13'd0,    13'd0},
    '{13'd1024, 2'd0, 13'd0, 13'd0,    13'd0},
    '{13'd36,   2'd0, 13'd0, 13'd0,    13'd0},
    '{13'd961,  2'd0, 13'd0, 13'd0,    13'd0},
    '{13'd6241, 2'd0, 13'd0, 13'd0,    13'd0},
    '{13'd2310, 2'd0, 13'd0, 13'd0,    13'd0},
    '{13'd5461, 2'd0, 13'd0, 13'd0,    13'd0},
    '{13'd2730, 2'd0, 13'd0, 13'd0,    13'd0},
    '{13'd16,   2'd0, 13'd0, 13'd0,    13'd0},
    '{13'd9,    2'd0, 13'd0, 13'd0,    13'd0},
    '{13'd6,    2'd0, 13'd0, 13'd0,    13'd0}
  };

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [NUM_W-1:0] in_number = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [NUM_W-1:0] out_divisor;
  logic             out_is_last;

  // typed-in expectation travelling with the request on offer
  logic [1:0]            fixed_cnt = '0;
  logic [2:0][NUM_W-1:0] fixed_vals = '0;

  div_result_t pending_divisors [$];
  logic [6:0]  small_tab [SMALL_CAP];
  logic [5:0]  small_tally = '0;
  int          mismatch_cnt = 0;
  int          results_seen = 0;
  bit          random_phase = 1'b0;
  bit          calm = 1'b0;

  divisor_enumerator_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_number  (in_number),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_divisor(out_divisor),
    .out_is_last(out_is_last)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("FAILURE");
    $finish;
  end

  // trial division up to the root, then mirrors of the stored divisors in reverse
  function automatic void enumerate_divisors(input logic [NUM_W-1:0] num);
    int unsigned cand, cnt, mirror, total, k, idx, top;
    cnt = 0;
    k = 0;
    if (num == '0) begin
      small_tally = '0;
      return;
    end
    for (cand = 1; cand * cand <= num; cand++) begin
      if (num % cand == 0 && cnt < SMALL_CAP) begin
        small_tab[cnt] = 7'(cand);
        cnt++;
      end
    end
    small_tally = 6'(cnt);
    mirror = cnt;
    top = small_tab[cnt-1];
    if (top * top == num) mirror = cnt - 1;
    total = cnt + mirror;
    for (idx = 0; idx < cnt; idx++) begin
      pending_divisors.push_back('{divisor: NUM_W'(small_tab[idx]), is_last: (k == total - 1)});
      k++;
    end
    for (idx = mirror; idx > 0; idx--) begin
      pending_divisors.push_back('{divisor: NUM_W'(num / small_tab[idx-1]),
                                   is_last: (k == total - 1)});
      k++;
    end
  endfunction

  always @(posedge clk) begin : monitor
    div_result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (pending_divisors.size() == 0) begin
          $display("%0t: unexpected divisor, expected none, got %0d last %0b",
                   $time, out_divisor, out_is_last);
          mismatch_cnt++;
        end else begin
          want = pending_divisors.pop_front();
          if (out_divisor !== want.divisor) begin
            $display("%0t: divisor mismatch, expected %0d, got %0d",
                     $time, want.divisor, out_divisor);
            mismatch_cnt++;
          end
          if (out_is_last !== want.is_last) begin
            $display("%0t: last flag mismatch on %0d, expected %0b, got %0b",
                     $time, want.divisor, want.is_last, out_is_last);
            mismatch_cnt++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (fixed_cnt != '0) begin
          for (int i = 0; i < fixed_cnt; i++)
            pending_divisors.push_back('{divisor: fixed_vals[i], is_last: (i == fixed_cnt - 1)});
        end else begin
          enumerate_divisors(in_number);
        end
      end
    end
  end

  // result side: random stalls, one long hold-off once the random part starts
  initial begin : sink
    bit held_long;
    held_long = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (random_phase && !held_long) begin
        held_long = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // returns at the edge where the request is taken
  task automatic offer(input logic [NUM_W-1:0] num, input logic [1:0] n_fixed,
                       input logic [2:0][NUM_W-1:0] vals);
    int gap;
    gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_number  <= num;
    fixed_cnt  <= n_fixed;
    fixed_vals <= vals;
    do @(posedge clk); while (!in_ready);
  endtask

  initial begin : stimulus
    int r;
    int unsigned num, root;
    repeat (RST_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (STIM_TAB[i])
      offer(STIM_TAB[i].number, STIM_TAB[i].n_fixed,
            {STIM_TAB[i].f2, STIM_TAB[i].f1, STIM_TAB[i].f0});
    random_phase = 1'b1;
    for (int j = 0; j < RAND_ITEMS; j++) begin
      if (j == RAND_ITEMS - CALM_ITEMS) calm = 1'b1;
      r = $urandom_range(0, 9);
      // half of them small numbers, which finish quickly
      if (r < 5) begin
        num = $urandom_range(1, 255);
      end else if (r < 7) begin
        num = $urandom_range(1, NUM_MAX);
      end else if (r == 7) begin
        root = $urandom_range(1, 90);
        num = root * root;
      end else if (r == 8) begin
        num = 60 * $urandom_range(1, 136);
      end else begin
        num = $urandom_range(NUM_MAX / 2 + 1, NUM_MAX);
      end
      offer(NUM_W'(num), 2'd0, '0);
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_divisors.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && pending_divisors.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

[divisor_enumerator_core.f]
hdl/divenum_pkg.sv
hdl/divenum_div.sv
hdl/divenum_dp.sv
hdl/divenum_ctrl.sv
hdl/divisor_enumerator_core.sv
hdl/divenum_chk.sv
tb/sv/tb_divisor_enumerator_core.sv
